>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hdl/dwg_pkg.sv
package dwg_pkg;

    localparam int SAMPLES        = 256;
    localparam int SINE_FRAC_BITS = 15;
    localparam int M_PTS          = SAMPLES - 1;
    localparam int HALF_PTS       = SAMPLES / 2;
    localparam int IDX_W          = $clog2(SAMPLES);
    localparam int SINE_W         = SINE_FRAC_BITS + 1;
    localparam int TICK_W         = 16;
    localparam int HALF_W         = 11;
    localparam int CODE_W         = 12;
    localparam int OUT_IDX_W      = 10;
    localparam int OPA_W          = CODE_W + 1;
    localparam int OPB_W          = (SINE_W > IDX_W) ? SINE_W : IDX_W;
    localparam int PROD_W         = OPA_W + OPB_W;
    localparam int NUM_W          = OPA_W + IDX_W - 1;
    localparam int RECIP_SHIFT    = 32;
    localparam logic [63:0] RECIP64 = (64'd1 << RECIP_SHIFT) / M_PTS;
    localparam int RECIP_W        = $clog2(RECIP64 + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);
    localparam int QPROD_W        = NUM_W + RECIP_W;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

    typedef enum logic [1:0] {
        SHAPE_SINE   = 2'd0,
        SHAPE_SAW    = 2'd1,
        SHAPE_SQUARE = 2'd2,
        SHAPE_TRI    = 2'd3
    } shape_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_SHAPE    = 3'd0,
        CFG_SAMPLE_PERIOD = 3'd1,
        CFG_SINE_HALF     = 3'd2,
        CFG_FULL_CODE     = 3'd3,
        CFG_TRI_PEAK      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        shape_t              wave_shape;
        logic [TICK_W-1:0]   sample_period;
        logic [HALF_W-1:0]   sine_half_code;
        logic [CODE_W-1:0]   full_code;
        logic [CODE_W-1:0]   tri_peak_code;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   idx;
    } point_t;

    typedef struct packed {
        logic               valid;
        shape_t             shape;
        logic [IDX_W-1:0]   idx;
        logic [PROD_W-1:0]  prod;
    } prod_item_t;

    typedef logic [SINE_W-1:0] sine_rom_t [SAMPLES];

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [63:0] sin_q60(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 12; n++)
        begin
            term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Table entry is 2^F plus the signed sine value, so it is never negative.
    function automatic logic [SINE_W-1:0] sine_entry(input int i);
        logic [63:0] four_i;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] mag;
        logic [63:0] lim;
        logic [63:0] one;
        four_i = 64'd4 * 64'(i);
        q      = four_i / 64'(M_PTS);
        rem    = four_i - q * 64'(M_PTS);
        r      = q[0] ? (64'(M_PTS) - rem) : rem;
        x      = (HALF_PI_Q60 / 64'(M_PTS)) * r + ((HALF_PI_Q60 % 64'(M_PTS)) * r) / 64'(M_PTS);
        s      = sin_q60(x);
        mag    = (s + (64'd1 << (59 - SINE_FRAC_BITS))) >> (60 - SINE_FRAC_BITS);
        one    = 64'd1 << SINE_FRAC_BITS;
        lim    = one - 64'd1;
        if (mag > lim)
        begin
            mag = lim;
        end
        return q[1] ? SINE_W'(one - mag) : SINE_W'(one + mag);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t t;
        for (int i = 0; i < SAMPLES; i++)
        begin
            t[i] = sine_entry(i);
        end
        return t;
    endfunction

endpackage

>>> hdl/dwg_sequencer.sv
module dwg_sequencer
    import dwg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              restart,
    input  logic [TICK_W-1:0] sample_period,
    input  logic              down_ready,
    output point_t            point
);

    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] tick_count_next;
    logic [IDX_W-1:0]  point_index_reg;
    logic [IDX_W-1:0]  point_index_next;
    logic              valid_reg;
    logic              valid_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  cur_idx;
    logic              accept;
    logic              fire;

    assign in_ready = !valid_reg || down_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cur_idx = ({1'b0, point_index_reg} >= (IDX_W + 1)'(SAMPLES)) ? '0 : point_index_reg;
        tick_count_next  = tick_count_reg;
        point_index_next = point_index_reg;
        fire             = 1'b0;
        if (accept)
        begin
            if (restart)
            begin
                tick_count_next  = '0;
                point_index_next = '0;
            end
            else if (tick_count_reg < sample_period)
            begin
                tick_count_next = tick_count_reg + TICK_W'(1);
            end
            else
            begin
                tick_count_next  = '0;
                fire             = 1'b1;
                point_index_next = (cur_idx == IDX_W'(M_PTS)) ? '0 : cur_idx + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (accept)
        begin
            valid_next = fire;
            idx_next   = cur_idx;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            point_index_reg <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            tick_count_reg  <= tick_count_next;
            point_index_reg <= point_index_next;
            valid_reg       <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    assign point.valid = valid_reg;
    assign point.idx   = idx_reg;

endmodule

>>> hdl/dwg_mult.sv
module dwg_mult
    import dwg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  point_t     point,
    output logic       up_ready,
    input  logic       down_ready,
    output prod_item_t item
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic              valid_reg;
    logic              valid_next;
    shape_t            shape_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [OPA_W-1:0]  op_a;
    logic [OPB_W-1:0]  op_b;
    logic              first_half;
    logic              load;

    assign up_ready   = !valid_reg || down_ready;
    assign load       = point.valid && up_ready;
    assign first_half = {1'b0, point.idx} < (IDX_W + 1)'(HALF_PTS);

    always_comb
    begin
        case (cfg.wave_shape)
            SHAPE_SINE:
            begin
                op_a = OPA_W'(cfg.sine_half_code);
                op_b = OPB_W'(SINE_ROM[point.idx]);
            end
            SHAPE_SAW:
            begin
                op_a = OPA_W'(cfg.full_code);
                op_b = OPB_W'(point.idx);
            end
            SHAPE_TRI:
            begin
                op_a = {cfg.tri_peak_code, 1'b0};
                op_b = first_half ? OPB_W'(point.idx) : OPB_W'(IDX_W'(M_PTS) - point.idx);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_next = PROD_W'(op_a) * PROD_W'(op_b);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = point.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shape_reg <= cfg.wave_shape;
            idx_reg   <= point.idx;
            prod_reg  <= prod_next;
        end
    end

    assign item.valid = valid_reg;
    assign item.shape = shape_reg;
    assign item.idx   = idx_reg;
    assign item.prod  = prod_reg;

endmodule

>>> hdl/dwg_scale.sv
module dwg_scale
    import dwg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CODE_W-1:0]    full_code,
    input  prod_item_t           item,
    output logic                 up_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CODE_W-1:0]    out_code,
    output logic [OUT_IDX_W-1:0] out_index,
    output logic                 out_last
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [CODE_W-1:0]    code_reg;
    logic [CODE_W-1:0]    code_next;
    logic [IDX_W-1:0]     idx_reg;
    logic                 last_reg;
    logic [NUM_W-1:0]     num;
    logic [QPROD_W-1:0]   qprod;
    logic [CODE_W:0]      q_est;
    logic [NUM_W-1:0]     rem;
    logic [CODE_W:0]      q_div;
    logic [CODE_W:0]      code_wide;
    logic                 load;

    assign up_ready = !valid_reg || out_ready;
    assign load     = item.valid && up_ready;

    // Division by M_PTS, one less than the point count: reciprocal estimate, low by at most one.
    always_comb
    begin
        num   = item.prod[NUM_W-1:0];
        qprod = QPROD_W'(num) * QPROD_W'(RECIP);
        q_est = qprod[RECIP_SHIFT +: (CODE_W + 1)];
        rem   = num - NUM_W'(NUM_W'(q_est) * NUM_W'(M_PTS));
        q_div = (rem >= NUM_W'(M_PTS)) ? q_est + (CODE_W + 1)'(1) : q_est;
        case (item.shape)
            SHAPE_SINE:
            begin
                code_wide = item.prod[SINE_FRAC_BITS +: (CODE_W + 1)];
            end
            SHAPE_SQUARE:
            begin
                code_wide = ({1'b0, item.idx} < (IDX_W + 1)'(HALF_PTS))
                          ? (CODE_W + 1)'(full_code) : '0;
            end
            default:
            begin
                code_wide = q_div;
            end
        endcase
        code_next = (code_wide > (CODE_W + 1)'(CODE_MAX)) ? CODE_MAX : code_wide[CODE_W-1:0];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = item.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg <= code_next;
            idx_reg  <= item.idx;
            last_reg <= (item.idx == IDX_W'(M_PTS));
        end
    end

    assign out_valid = valid_reg;
    assign out_code  = code_reg;
    assign out_index = OUT_IDX_W'(idx_reg);
    assign out_last  = last_reg;

endmodule

>>> hdl/dac_waveform_generator.sv
// A sampled tick's result is registered by the sequencer, multiplier and scaler in turn.
// Throughput: one tick item per cycle unless stalled; s_tready is high whenever m_tready is high.
// The result path is three registered stages: tick counter, multiplier, scaling and output.
// Reset (rst_n low, asynchronous) clears both counters and the pipeline valid bits
// and loads the configuration defaults: sine, period 140, half 2047, full 4095, peak 1240.
module dac_waveform_generator
    import dwg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] restart, [7:1] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [11:0] dac_code, [21:12] sample_index, [23:22] zero
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t                 cfg_reg;
    point_t               point;
    prod_item_t           item;
    logic                 mult_ready;
    logic                 scale_ready;
    logic [CODE_W-1:0]    out_code;
    logic [OUT_IDX_W-1:0] out_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_shape     <= SHAPE_SINE;
            cfg_reg.sample_period  <= TICK_W'(140);
            cfg_reg.sine_half_code <= HALF_W'(2047);
            cfg_reg.full_code      <= CODE_W'(4095);
            cfg_reg.tri_peak_code  <= CODE_W'(1240);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WAVE_SHAPE:    cfg_reg.wave_shape     <= shape_t'(cfg_wdata[1:0]);
                CFG_SAMPLE_PERIOD: cfg_reg.sample_period  <= cfg_wdata[TICK_W-1:0];
                CFG_SINE_HALF:     cfg_reg.sine_half_code <= cfg_wdata[HALF_W-1:0];
                CFG_FULL_CODE:     cfg_reg.full_code      <= cfg_wdata[CODE_W-1:0];
                CFG_TRI_PEAK:      cfg_reg.tri_peak_code  <= cfg_wdata[CODE_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    dwg_sequencer u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .restart       (s_tdata[0]),
        .sample_period (cfg_reg.sample_period),
        .down_ready    (mult_ready),
        .point         (point)
    );

    dwg_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .point      (point),
        .up_ready   (mult_ready),
        .down_ready (scale_ready),
        .item       (item)
    );

    dwg_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .full_code (cfg_reg.full_code),
        .item      (item),
        .up_ready  (scale_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (out_code),
        .out_index (out_index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_index, out_code};

endmodule

>>> hdl/dwg_checker.sv
`include "assert_macros.svh"

module dwg_checker
    import dwg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    `ASSERT_IMPLIES(a_ready_follows, clk, rst_n, m_tready, s_tready, "input stalled while output is free")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
    `ASSERT_IMPLIES(a_last_index, clk, rst_n, m_tvalid && m_tlast, m_tdata[21:12] == OUT_IDX_W'(M_PTS), "tlast on a sample that is not the last")
    `ASSERT_IMPLIES(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[23:22] == 2'b00, "padding bits not zero")

endmodule

bind dac_waveform_generator dwg_checker u_dwg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/tb_dac_waveform_generator.sv
`timescale 1ns / 100ps

import dwg_pkg::*;

typedef struct packed {
    logic [CODE_W-1:0]    code;
    logic [OUT_IDX_W-1:0] idx;
    logic                 last;
} dac_sample_t;

class waveform_scoreboard;
    shape_t             shape;
    logic [TICK_W-1:0]  period;
    logic [HALF_W-1:0]  half;
    logic [CODE_W-1:0]  full;
    logic [CODE_W-1:0]  peak;
    int unsigned        tick_cnt;
    int unsigned        point;
    int                 sine_tab [SAMPLES];
    dac_sample_t        due_samples [$];
    int                 errors;
    int                 ticks;
    int                 restarts;
    int                 samples;
    int                 writes;

    function new();
        shape    = SHAPE_SINE;
        period   = 16'd140;
        half     = 11'd2047;
        full     = 12'd4095;
        peak     = 12'd1240;
        tick_cnt = 0;
        point    = 0;
        errors   = 0;
        ticks    = 0;
        restarts = 0;
        samples  = 0;
        writes   = 0;
        for (int i = 0; i < SAMPLES; i++)
        begin
            sine_tab[i] = sine_q(i);
        end
    endfunction

    function logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] wide;
        wide = {64'd0, a};
        wide = wide * {64'd0, b};
        return wide[123:60];
    endfunction

    // Taylor series of sin(x) for x in [0, pi/2], everything in Q60.
    function logic [63:0] taylor_sin(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        x2   = q60_mul(x, x);
        term = x;
        acc  = x;
        for (int n = 1; n <= 12; n++)
        begin
            term = q60_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - term : acc + term;
        end
        return acc;
    endfunction

    // Signed sine of 2*pi*i/(SAMPLES-1) with SINE_FRAC_BITS fraction bits.
    function int sine_q(int i);
        longint unsigned m;
        longint unsigned q4;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned r;
        longint unsigned ang;
        longint unsigned s;
        longint unsigned mag;
        longint unsigned lim;
        m    = 64'(M_PTS);
        q4   = 64'd4 * 64'(i);
        quad = q4 / m;
        rem  = q4 - quad * m;
        r    = (quad % 64'd2 == 64'd1) ? m - rem : rem;
        ang  = (HALF_PI_Q60 / m) * r + ((HALF_PI_Q60 % m) * r) / m;
        s    = taylor_sin(ang);
        mag  = (s + (64'd1 << (59 - SINE_FRAC_BITS))) >> (60 - SINE_FRAC_BITS);
        lim  = (64'd1 << SINE_FRAC_BITS) - 64'd1;
        if (mag > lim)
        begin
            mag = lim;
        end
        return ((quad % 64'd4) >= 64'd2) ? -int'(mag) : int'(mag);
    endfunction

    function logic [CODE_W-1:0] wave_code(int unsigned i);
        longint c;
        case (shape)
            SHAPE_SINE:
            begin
                c = longint'(half) * (longint'(1) <<< SINE_FRAC_BITS)
                    + longint'(half) * longint'(sine_tab[i]);
                if (c < 0)
                begin
                    c = 0;
                end
                c = c >>> SINE_FRAC_BITS;
            end
            SHAPE_SAW:
            begin
                c = longint'(full) * longint'(i) / longint'(M_PTS);
            end
            SHAPE_SQUARE:
            begin
                c = (i < HALF_PTS) ? longint'(full) : longint'(0);
            end
            default:
            begin
                if (i < HALF_PTS)
                begin
                    c = 2 * longint'(peak) * longint'(i) / longint'(M_PTS);
                end
                else
                begin
                    c = 2 * longint'(peak) * longint'(M_PTS - i) / longint'(M_PTS);
                end
            end
        endcase
        if (c > longint'(CODE_MAX))
        begin
            c = longint'(CODE_MAX);
        end
        return CODE_W'(c);
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        writes++;
        case (idx)
            CFG_WAVE_SHAPE:    shape  = shape_t'(data[1:0]);
            CFG_SAMPLE_PERIOD: period = data[TICK_W-1:0];
            CFG_SINE_HALF:     half   = data[HALF_W-1:0];
            CFG_FULL_CODE:     full   = data[CODE_W-1:0];
            CFG_TRI_PEAK:      peak   = data[CODE_W-1:0];
            default:           ;
        endcase
    endfunction

    function void take_tick(logic restart_bit);
        dac_sample_t s;
        int unsigned i;
        ticks++;
        if (restart_bit)
        begin
            restarts++;
            tick_cnt = 0;
            point    = 0;
            return;
        end
        if (tick_cnt < period)
        begin
            tick_cnt++;
            return;
        end
        tick_cnt = 0;
        i        = (point >= SAMPLES) ? 0 : point;
        s.code   = wave_code(i);
        s.idx    = OUT_IDX_W'(i);
        s.last   = (i == M_PTS);
        due_samples.push_back(s);
        point    = (i + 1 >= SAMPLES) ? 0 : i + 1;
    endfunction

    function void check_sample(logic [CODE_W-1:0] code, logic [OUT_IDX_W-1:0] idx, logic last);
        dac_sample_t want;
        if (due_samples.size() == 0)
        begin
            $error("Unexpected sample: dac_code %0d, sample_index %0d", code, idx);
            errors++;
            return;
        end
        want = due_samples.pop_front();
        samples++;
        if (code !== want.code)
        begin
            $error("dac_code: expected %0d, actual %0d", want.code, code);
            errors++;
        end
        if (idx !== want.idx)
        begin
            $error("sample_index: expected %0d, actual %0d", want.idx, idx);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("period_end: expected %0b, actual %0b", want.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return due_samples.size();
    endfunction
endclass

module tb_dac_waveform_generator;

    localparam int PIPE_DEPTH  = 3;
    localparam int STALL_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX = CFG_IDX_W'(CFG_TRI_PEAK) + CFG_IDX_W'(1);

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    waveform_scoreboard   sb;
    logic                 steady = 1'b0;
    int                   stall_cycles = 0;

    dac_waveform_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 34);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.take_tick(s_tdata[0]);
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_sample(m_tdata[11:0], m_tdata[21:12], m_tlast);
            end
        end
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles = stall_cycles + 1;
        end
    end

    initial
    begin
        do
        begin
            @(posedge clk);
        end
        while (stall_cycles < STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.apply_write(idx, data);
    endtask

    task automatic send_tick(input logic restart_bit);
        cfg_we <= 1'b0;
        while (!steady && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 8'(restart_bit);
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input int n, input int restart_pct);
        for (int k = 0; k < n; k++)
        begin
            send_tick($urandom_range(99) < restart_pct);
        end
    endtask

    // Wait until every sample is out and ticks that give no sample have left the pipeline.
    task automatic settle();
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] reg_value(input int w);
        logic [CFG_W-1:0] v;
        case ($urandom_range(3))
            0:       v = '0;
            1:       v = CFG_W'((1 << w) - 1);
            default: v = CFG_W'($urandom_range((1 << w) - 1));
        endcase
        if (w < CFG_W && $urandom_range(3) == 0)
        begin
            v = v | CFG_W'($urandom << w);
        end
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] period_value();
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return '0;
            10, 11, 12, 13, 14, 15:       return CFG_W'($urandom_range(3, 1));
            16, 17, 18:                   return CFG_W'($urandom_range(20, 4));
            default:                      return $urandom_range(1) ? '1 : CFG_W'($urandom);
        endcase
    endfunction

    task automatic shuffle_config();
        if ($urandom_range(1))
        begin
            write_reg(CFG_WAVE_SHAPE, reg_value(2));
        end
        if ($urandom_range(1))
        begin
            write_reg(CFG_SAMPLE_PERIOD, period_value());
        end
        if ($urandom_range(1))
        begin
            write_reg(CFG_SINE_HALF, reg_value(HALF_W));
        end
        if ($urandom_range(1))
        begin
            write_reg(CFG_FULL_CODE, reg_value(CODE_W));
        end
        if ($urandom_range(1))
        begin
            write_reg(CFG_TRI_PEAK, reg_value(CODE_W));
        end
        if ($urandom_range(7) == 0)
        begin
            write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, SPARE_INDEX)), CFG_W'($urandom));
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_WAVE_SHAPE, CFG_W'(SHAPE_SINE));
        write_reg(CFG_SAMPLE_PERIOD, '0);
        write_reg(CFG_SINE_HALF, CFG_W'({HALF_W{1'b1}}));
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        settle();

        write_reg(CFG_WAVE_SHAPE, CFG_W'(SHAPE_SAW));
        write_reg(CFG_FULL_CODE, CFG_W'(CODE_MAX));
        repeat (3) send_tick(1'b0);
        settle();

        write_reg(CFG_WAVE_SHAPE, CFG_W'(SHAPE_SQUARE));
        write_reg(CFG_FULL_CODE, '0);
        repeat (2) send_tick(1'b0);
        settle();

        write_reg(CFG_WAVE_SHAPE, CFG_W'(SHAPE_TRI));
        write_reg(CFG_TRI_PEAK, CFG_W'(CODE_MAX));
        repeat (2) send_tick(1'b0);
        settle();

        // The count runs up under the longest period, then the period drops below it.
        write_reg(CFG_WAVE_SHAPE, CFG_W'(SHAPE_SINE));
        write_reg(CFG_SINE_HALF, '0);
        write_reg(CFG_SAMPLE_PERIOD, '1);
        repeat (6) send_tick(1'b0);
        settle();
        write_reg(CFG_SAMPLE_PERIOD, CFG_W'(2));
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        settle();

        // One full waveform period and more, back to back with no gaps.
        write_reg(CFG_WAVE_SHAPE, CFG_W'($urandom_range(3)));
        write_reg(CFG_SAMPLE_PERIOD, '0);
        steady = 1'b1;
        run_phase(SAMPLES + 14, 0);
        steady = 1'b0;
        settle();

        while (sb.ticks < 530 || sb.samples < 60)
        begin
            shuffle_config();
            steady = ($urandom_range(4) == 0);
            run_phase($urandom_range(60, 20), ($urandom_range(2) == 0) ? 4 : 0);
            steady = 1'b0;
            settle();
        end

        repeat (PIPE_DEPTH * 4) @(posedge clk);
        $display("Sent %0d ticks with %0d restarts and checked %0d samples.",
                 sb.ticks, sb.restarts, sb.samples);
        $display("Used all four shapes over %0d register writes, periods from zero to the maximum.",
                 sb.writes);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
